// File: src/tpfs_pkg.sv
// ----------------------------------------------------------------------------
// tpfs_pkg
// Shared types and constants of the tensor polynomial feature series block.
// ----------------------------------------------------------------------------
package tpfs_pkg;

    localparam int COORD_W     = 32;
    localparam int TERM_W      = 32;
    localparam int INDEX_W     = 6;
    localparam int LEN_W       = 7;
    localparam int DEG_W       = 6;
    localparam int FRAC_BITS   = 16;
    localparam int MUL_DIGIT_W = 16;
    localparam int APB_ADDR_W  = 3;
    localparam int APB_DATA_W  = 32;

    localparam logic [LEN_W-1:0] LEN_RESET = 7'd64;
    localparam logic [DEG_W-1:0] DEG_RESET = 6'd1;

    // Register index, taken from paddr[2].
    localparam logic REG_SERIES_LENGTH = 1'b0;
    localparam logic REG_MAX_DEGREE    = 1'b1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_x;
        logic power_from_x;
        logic power_from_mul;
        logic mul_start;
        logic mul_use_x;
        logic mem_rd;
        logic emit_one;
        logic emit_term;
        logic run_last;
    } tpfs_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic mul_done;
        logic out_free;
    } tpfs_stat_t;

endpackage

// File: src/tpfs_if.sv
// ----------------------------------------------------------------------------
// tpfs channel interfaces
// Valid/ready channels for coordinates in and series terms out.
// ----------------------------------------------------------------------------
interface tpfs_coord_if
    import tpfs_pkg::*;
    ();
    logic               valid;
    logic               ready;
    logic [COORD_W-1:0] coord_value;
    logic               last_coord;

    modport source (output valid, output coord_value, output last_coord, input ready);
    modport sink   (input valid, input coord_value, input last_coord, output ready);
endinterface

interface tpfs_term_if
    import tpfs_pkg::*;
    ();
    logic               valid;
    logic               ready;
    logic [TERM_W-1:0]  term_value;
    logic [INDEX_W-1:0] term_index;
    logic               saturated;
    logic               run_last;

    modport source (output valid, output term_value, output term_index,
                    output saturated, output run_last, input ready);
    modport sink   (input valid, input term_value, input term_index,
                    input saturated, input run_last, output ready);
endinterface

// File: src/tpfs_mul.sv
// ----------------------------------------------------------------------------
// tpfs_mul
// Multi-cycle signed Q16.16 multiplier: one 16-bit digit of the magnitude
// per cycle, then floor rounding and saturation to the data width.
// ----------------------------------------------------------------------------
module tpfs_mul
    import tpfs_pkg::*;
#(
    parameter int DATA_WIDTH = 32
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [DATA_WIDTH-1:0] a,
    input  logic [DATA_WIDTH-1:0] b,
    output logic [DATA_WIDTH-1:0] result,
    output logic                  sat,
    output logic                  done
);

    localparam int NDIG  = (DATA_WIDTH + MUL_DIGIT_W - 1) / MUL_DIGIT_W;
    localparam int MBW   = NDIG * MUL_DIGIT_W;
    localparam int PW    = 2 * DATA_WIDTH;
    localparam int CNT_W = $clog2(NDIG + 1);
    localparam logic [PW-1:0] HALF = PW'(1) << (DATA_WIDTH - 1);

    typedef enum logic [1:0] {
        M_IDLE,
        M_MAC,
        M_RND,
        M_FIT
    } mstate_t;

    mstate_t                 state_reg, state_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic                    done_reg, done_next;
    logic                    neg_reg;
    logic [DATA_WIDTH-1:0]   ma_reg;
    logic [MBW-1:0]          mb_reg;
    logic [PW-1:0]           acc_reg;
    logic [DATA_WIDTH-1:0]   result_reg;
    logic                    sat_reg;

    logic [DATA_WIDTH+MUL_DIGIT_W-1:0] part;
    logic [PW-1:0]           mag;
    logic [PW-1:0]           lim;
    logic [PW-1:0]           clamped;
    logic                    over;

    assign part    = ma_reg * mb_reg[MBW-1 -: MUL_DIGIT_W];
    assign mag     = acc_reg >> FRAC_BITS;
    assign lim     = neg_reg ? HALF : HALF - PW'(1);
    assign over    = mag > lim;
    assign clamped = over ? lim : mag;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        done_next  = 1'b0;
        unique case (state_reg)
            M_IDLE:
            begin
                if (start)
                begin
                    state_next = M_MAC;
                    cnt_next   = CNT_W'(NDIG);
                end
            end
            M_MAC:
            begin
                cnt_next = cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    state_next = M_RND;
                end
            end
            M_RND:
            begin
                state_next = M_FIT;
            end
            M_FIT:
            begin
                state_next = M_IDLE;
                done_next  = 1'b1;
            end
            default:
            begin
                state_next = M_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= M_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == M_IDLE && start)
        begin
            neg_reg <= a[DATA_WIDTH-1] ^ b[DATA_WIDTH-1];
            ma_reg  <= a[DATA_WIDTH-1] ? (~a + 1'b1) : a;
            mb_reg  <= MBW'(b[DATA_WIDTH-1] ? (~b + 1'b1) : b);
            acc_reg <= '0;
        end
        else if (state_reg == M_MAC)
        begin
            // Most significant digit first, so the accumulator shifts up.
            acc_reg <= (acc_reg << MUL_DIGIT_W) + PW'(part);
            mb_reg  <= mb_reg << MUL_DIGIT_W;
        end
        else if (state_reg == M_RND)
        begin
            // Negative products round toward minus infinity on the magnitude.
            acc_reg <= acc_reg + (neg_reg ? PW'(16'hFFFF) : PW'(0));
        end
        else if (state_reg == M_FIT)
        begin
            result_reg <= neg_reg ? (~clamped[DATA_WIDTH-1:0] + 1'b1)
                                  : clamped[DATA_WIDTH-1:0];
            sat_reg    <= over;
        end
    end

    assign result = result_reg;
    assign sat    = sat_reg;
    assign done   = done_reg;

endmodule

// File: src/tpfs_datapath.sv
// ----------------------------------------------------------------------------
// tpfs_datapath
// Coordinate and power registers, the term store, the multiplier and the
// output register of the term channel.
// ----------------------------------------------------------------------------
module tpfs_datapath
    import tpfs_pkg::*;
#(
    parameter int MAX_TERMS  = 64,
    parameter int DATA_WIDTH = 32
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic [COORD_W-1:0]             coord_value,
    input  tpfs_cmd_t                      cmd,
    input  logic [$clog2(MAX_TERMS+1)-1:0] rd_addr,
    input  logic [$clog2(MAX_TERMS+1)-1:0] wr_idx,
    output tpfs_stat_t                     stat,
    tpfs_term_if.source                    term
);

    localparam int AW = $clog2(MAX_TERMS);
    localparam logic signed [63:0] XMAX = (64'sd1 <<< (DATA_WIDTH - 1)) - 64'sd1;
    localparam logic signed [63:0] XMIN = -(64'sd1 <<< (DATA_WIDTH - 1));
    localparam logic [DATA_WIDTH-1:0] ONE_VAL =
        (DATA_WIDTH >= 18) ? DATA_WIDTH'(64'd1 << FRAC_BITS)
                           : {1'b0, {(DATA_WIDTH-1){1'b1}}};
    localparam logic ONE_SAT = (DATA_WIDTH < 18);

    logic [DATA_WIDTH-1:0] store_mem [MAX_TERMS];
    logic [DATA_WIDTH-1:0] rdata_reg;
    logic [DATA_WIDTH-1:0] x_reg;
    logic [DATA_WIDTH-1:0] power_reg;
    logic                  psat_reg;

    logic                  out_valid_reg;
    logic [TERM_W-1:0]     out_value_reg;
    logic [INDEX_W-1:0]    out_index_reg;
    logic                  out_sat_reg;
    logic                  out_last_reg;

    logic signed [63:0]    coord_wide;
    logic signed [63:0]    coord_fit;
    logic [DATA_WIDTH-1:0] mul_b;
    logic [DATA_WIDTH-1:0] mul_result;
    logic                  mul_sat;
    logic                  mul_done;

    assign coord_wide = 64'($signed(coord_value));

    always_comb
    begin
        priority if (coord_wide > XMAX)
        begin
            coord_fit = XMAX;
        end
        else if (coord_wide < XMIN)
        begin
            coord_fit = XMIN;
        end
        else
        begin
            coord_fit = coord_wide;
        end
    end

    assign mul_b = cmd.mul_use_x ? x_reg : rdata_reg;

    tpfs_mul #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_mul (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (cmd.mul_start),
        .a      (power_reg),
        .b      (mul_b),
        .result (mul_result),
        .sat    (mul_sat),
        .done   (mul_done)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.load_x)
        begin
            x_reg <= DATA_WIDTH'(coord_fit);
        end
        if (cmd.power_from_x)
        begin
            power_reg <= x_reg;
            psat_reg  <= 1'b0;
        end
        else if (cmd.power_from_mul)
        begin
            // Once x^k clamps, every later power of this coordinate is flagged.
            power_reg <= mul_result;
            psat_reg  <= psat_reg | mul_sat;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit_one)
        begin
            store_mem[0] <= ONE_VAL;
        end
        else if (cmd.emit_term)
        begin
            store_mem[wr_idx[AW-1:0]] <= mul_result;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mem_rd)
        begin
            rdata_reg <= store_mem[rd_addr[AW-1:0]];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit_one || cmd.emit_term)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (term.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit_one)
        begin
            out_value_reg <= TERM_W'($signed(ONE_VAL));
            out_index_reg <= '0;
            out_sat_reg   <= ONE_SAT;
            out_last_reg  <= cmd.run_last;
        end
        else if (cmd.emit_term)
        begin
            out_value_reg <= TERM_W'($signed(mul_result));
            out_index_reg <= INDEX_W'(wr_idx);
            out_sat_reg   <= psat_reg | mul_sat;
            out_last_reg  <= cmd.run_last;
        end
    end

    assign stat.mul_done = mul_done;
    assign stat.out_free = !out_valid_reg || term.ready;

    assign term.valid      = out_valid_reg;
    assign term.term_value = out_value_reg;
    assign term.term_index = out_index_reg;
    assign term.saturated  = out_sat_reg;
    assign term.run_last   = out_last_reg;

endmodule

// File: src/tpfs_ctrl.sv
// ----------------------------------------------------------------------------
// tpfs_ctrl
// Sequencer over degrees and stored terms; owns the series counters and
// drives the datapath by commands.
// ----------------------------------------------------------------------------
module tpfs_ctrl
    import tpfs_pkg::*;
#(
    parameter int MAX_TERMS = 64
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic                           last_coord,
    input  logic [LEN_W-1:0]               series_length,
    input  logic [DEG_W-1:0]               max_degree,
    input  tpfs_stat_t                     stat,
    output tpfs_cmd_t                      cmd,
    output logic [$clog2(MAX_TERMS+1)-1:0] rd_addr,
    output logic [$clog2(MAX_TERMS+1)-1:0] wr_idx
);

    localparam int CNTW = $clog2(MAX_TERMS + 1);
    localparam int KW   = DEG_W + 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ONE,
        S_KTOP,
        S_PWAIT,
        S_JTOP,
        S_JMUL,
        S_JWAIT,
        S_EMIT
    } state_t;

    state_t          state_reg, state_next;
    logic [CNTW-1:0] produced_reg, produced_next;
    logic [CNTW-1:0] base_reg, base_next;
    logic [CNTW-1:0] j_reg, j_next;
    logic [CNTW-1:0] limit_reg, limit_next;
    logic [KW-1:0]   k_reg, k_next;
    logic            last_reg, last_next;

    logic [CNTW-1:0] limit_calc;
    logic [KW-1:0]   deg_ext;
    logic [CNTW:0]   produced_inc;
    logic [CNTW:0]   j_inc;

    assign deg_ext      = KW'(max_degree);
    assign produced_inc = {1'b0, produced_reg} + (CNTW+1)'(1);
    assign j_inc        = {1'b0, j_reg} + (CNTW+1)'(1);

    always_comb
    begin
        priority if (series_length == '0)
        begin
            limit_calc = CNTW'(1);
        end
        else if (series_length > LEN_W'(MAX_TERMS))
        begin
            limit_calc = CNTW'(MAX_TERMS);
        end
        else
        begin
            limit_calc = CNTW'(series_length);
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        produced_next = produced_reg;
        base_next     = base_reg;
        j_next        = j_reg;
        limit_next    = limit_reg;
        k_next        = k_reg;
        last_next     = last_reg;
        cmd           = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_x = 1'b1;
                    last_next  = last_coord;
                    limit_next = limit_calc;
                    k_next     = KW'(1);
                    state_next = (produced_reg == '0) ? S_ONE : S_KTOP;
                end
            end
            S_ONE:
            begin
                if (stat.out_free)
                begin
                    cmd.emit_one  = 1'b1;
                    cmd.run_last  = !((max_degree != '0) && (limit_reg > CNTW'(1)));
                    produced_next = CNTW'(1);
                    base_next     = CNTW'(1);
                    state_next    = S_KTOP;
                end
            end
            S_KTOP:
            begin
                if (k_reg <= deg_ext && produced_reg < limit_reg)
                begin
                    j_next = '0;
                    if (k_reg == KW'(1))
                    begin
                        cmd.power_from_x = 1'b1;
                        state_next       = S_JTOP;
                    end
                    else
                    begin
                        cmd.mul_start = 1'b1;
                        cmd.mul_use_x = 1'b1;
                        state_next    = S_PWAIT;
                    end
                end
                else
                begin
                    // The terms of this coordinate become the base of the next.
                    base_next = produced_reg;
                    if (last_reg)
                    begin
                        produced_next = '0;
                        base_next     = '0;
                    end
                    state_next = S_IDLE;
                end
            end
            S_PWAIT:
            begin
                if (stat.mul_done)
                begin
                    cmd.power_from_mul = 1'b1;
                    state_next         = S_JTOP;
                end
            end
            S_JTOP:
            begin
                if (j_reg < base_reg && produced_reg < limit_reg)
                begin
                    cmd.mem_rd = 1'b1;
                    state_next = S_JMUL;
                end
                else
                begin
                    k_next     = k_reg + KW'(1);
                    state_next = S_KTOP;
                end
            end
            S_JMUL:
            begin
                cmd.mul_start = 1'b1;
                state_next    = S_JWAIT;
            end
            S_JWAIT:
            begin
                if (stat.mul_done)
                begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (stat.out_free)
                begin
                    cmd.emit_term = 1'b1;
                    cmd.run_last  = (produced_inc >= {1'b0, limit_reg}) ||
                                    ((j_inc >= {1'b0, base_reg}) && (k_reg >= deg_ext));
                    produced_next = produced_inc[CNTW-1:0];
                    j_next        = j_inc[CNTW-1:0];
                    state_next    = S_JTOP;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            produced_reg <= '0;
            base_reg     <= '0;
            j_reg        <= '0;
            limit_reg    <= CNTW'(1);
            k_reg        <= '0;
            last_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            produced_reg <= produced_next;
            base_reg     <= base_next;
            j_reg        <= j_next;
            limit_reg    <= limit_next;
            k_reg        <= k_next;
            last_reg     <= last_next;
        end
    end

    assign in_ready = (state_reg == S_IDLE);
    assign rd_addr  = j_reg;
    assign wr_idx   = produced_reg;

    a_emit_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit_one || cmd.emit_term) |-> stat.out_free)
        else $error("term emitted while the output register is occupied");

    a_one_first: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit_one |-> (produced_reg == '0))
        else $error("leading one emitted into a series that is not empty");

    a_term_below_limit: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit_term |-> (produced_reg < limit_reg && j_reg < base_reg))
        else $error("term emitted outside the series bounds");

    a_one_action: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.emit_one, cmd.emit_term, cmd.mul_start, cmd.mem_rd}))
        else $error("conflicting datapath commands");

    a_idle_counts: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> (base_reg == produced_reg))
        else $error("base count out of step between coordinates");

endmodule

// File: src/tensor_polynomial_feature_series.sv
// ----------------------------------------------------------------------------
// tensor_polynomial_feature_series
// Tensor-product polynomial feature series in signed Q16.16.
//
//   channel  dir  handshake        payload
//   coord    in   valid/ready      coord_value[31:0], last_coord
//   term     out  valid/ready      term_value[31:0], term_index[5:0],
//                                  saturated, run_last
//   apb      in   psel/penable     paddr[2:0], pwdata/prdata[31:0]
//
// Each term takes one store read plus one pass of the digit-serial
// multiplier, which works on NDIG = ceil(DATA_WIDTH/16) digits. Each degree
// above the first adds one power multiply; each degree closes its term loop
// in S_JTOP, the first degree loads the coordinate as the power, the leading
// one is emitted from S_ONE, and each coordinate passes S_IDLE and S_KTOP.
// A coordinate is accepted only while the sequencer is idle; a stalled term
// output holds the sequencer at its next emit. Reset clears the counters;
// the term store is not cleared, as only entries of the current vector are read.
// ----------------------------------------------------------------------------
module tensor_polynomial_feature_series
    import tpfs_pkg::*;
#(
    parameter int MAX_TERMS  = 64,
    parameter int DATA_WIDTH = 32
) (
    input  logic                  clk,
    input  logic                  rst_n,
    tpfs_coord_if.sink            coord,
    tpfs_term_if.source           term,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int CNTW = $clog2(MAX_TERMS + 1);

    logic [LEN_W-1:0] series_length_reg;
    logic [DEG_W-1:0] max_degree_reg;
    logic             cfg_write;
    logic             reg_sel;

    tpfs_cmd_t        cmd;
    tpfs_stat_t       stat;
    logic [CNTW-1:0]  rd_addr;
    logic [CNTW-1:0]  wr_idx;

    assign pready    = 1'b1;
    assign reg_sel   = paddr[2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            series_length_reg <= LEN_RESET;
            max_degree_reg    <= DEG_RESET;
        end
        else if (cfg_write)
        begin
            unique case (reg_sel)
                REG_SERIES_LENGTH: series_length_reg <= pwdata[LEN_W-1:0];
                REG_MAX_DEGREE:    max_degree_reg    <= pwdata[DEG_W-1:0];
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_sel)
            REG_SERIES_LENGTH: prdata = APB_DATA_W'(series_length_reg);
            REG_MAX_DEGREE:    prdata = APB_DATA_W'(max_degree_reg);
            default:           prdata = '0;
        endcase
    end

    tpfs_ctrl #(
        .MAX_TERMS (MAX_TERMS)
    ) u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (coord.valid),
        .in_ready      (coord.ready),
        .last_coord    (coord.last_coord),
        .series_length (series_length_reg),
        .max_degree    (max_degree_reg),
        .stat          (stat),
        .cmd           (cmd),
        .rd_addr       (rd_addr),
        .wr_idx        (wr_idx)
    );

    tpfs_datapath #(
        .MAX_TERMS  (MAX_TERMS),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .coord_value (coord.coord_value),
        .cmd         (cmd),
        .rd_addr     (rd_addr),
        .wr_idx      (wr_idx),
        .stat        (stat),
        .term        (term)
    );

endmodule

// File: tb/sv/tpfs_series_checker.sv
// ----------------------------------------------------------------------------
// tpfs_series_checker
// Watches the coordinate, term and register channels of the feature series
// block. It predicts every term from the accepted coordinates and the written
// registers, then compares each term beat with the oldest expected one.
// ----------------------------------------------------------------------------
module tpfs_series_checker
    import tpfs_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    tpfs_coord_if                 coord,
    tpfs_term_if                  term,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic                  pready,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output int                    mismatches,
    output int                    outstanding
);

    localparam int                       STORE_DEPTH = 64;
    localparam int                       REPORT_MAX  = 10;
    localparam logic [TERM_W-1:0]        Q_ONE       = 32'h0001_0000;
    localparam logic signed [63:0]       Q_MAX       = 64'sh0000_0000_7FFF_FFFF;
    localparam logic signed [63:0]       Q_MIN       = -64'sh0000_0000_8000_0000;

    typedef struct packed {
        logic [TERM_W-1:0]  value;
        logic [INDEX_W-1:0] index;
        logic               saturated;
        logic               run_last;
    } term_beat_t;

    term_beat_t        expected_terms[$];
    logic [TERM_W-1:0] series_store [STORE_DEPTH];
    int                produced;
    int                base;
    logic [LEN_W-1:0]  length_cfg;
    logic [DEG_W-1:0]  degree_cfg;

    // Q16.16 product, floored, clamped to the signed 32-bit range.
    function automatic logic [TERM_W-1:0] q_mul(input logic [TERM_W-1:0] a,
                                                input logic [TERM_W-1:0] b,
                                                inout logic sat);
        logic signed [63:0] wa;
        logic signed [63:0] wb;
        logic signed [63:0] prod;
        wa   = $signed(a);
        wb   = $signed(b);
        prod = (wa * wb) >>> FRAC_BITS;
        if (prod > Q_MAX)
        begin
            sat = 1'b1;
            return 32'h7FFF_FFFF;
        end
        if (prod < Q_MIN)
        begin
            sat = 1'b1;
            return 32'h8000_0000;
        end
        return prod[TERM_W-1:0];
    endfunction

    task automatic extend_series(input logic [COORD_W-1:0] x, input logic last);
        term_beat_t        batch [STORE_DEPTH];
        int                n;
        int                limit;
        int                k;
        int                j;
        logic              psat;
        logic              s;
        logic [TERM_W-1:0] power;
        logic [TERM_W-1:0] v;
        n     = 0;
        psat  = 1'b0;
        power = '0;
        limit = (length_cfg == 0) ? 1 : ((length_cfg > STORE_DEPTH) ? STORE_DEPTH
                                                                     : int'(length_cfg));
        if (produced == 0)
        begin
            series_store[0] = Q_ONE;
            batch[n]        = '{Q_ONE, '0, 1'b0, 1'b0};
            n++;
            produced = 1;
            base     = 1;
        end
        for (k = 1; k <= degree_cfg && produced < limit; k++)
        begin
            // Once a power has clamped, every later power of this coordinate
            // keeps the saturated flag.
            power = (k == 1) ? x : q_mul(power, x, psat);
            for (j = 0; j < base && produced < limit; j++)
            begin
                s                      = psat;
                v                      = q_mul(power, series_store[j], s);
                series_store[produced] = v;
                batch[n]               = '{v, produced[INDEX_W-1:0], s, 1'b0};
                n++;
                produced++;
            end
        end
        base = produced;
        if (last)
        begin
            produced = 0;
            base     = 0;
        end
        if (n > 0)
            batch[n-1].run_last = 1'b1;
        for (j = 0; j < n; j++)
            expected_terms = {expected_terms, batch[j]};
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        term_beat_t want;
        if (!rst_n)
        begin
            expected_terms.delete();
            produced    = 0;
            base        = 0;
            length_cfg  = LEN_RESET;
            degree_cfg  = DEG_RESET;
            mismatches  = 0;
            outstanding = 0;
        end
        else
        begin
            if (term.valid && term.ready)
            begin
                if (expected_terms.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX)
                        $display("unexpected term beat: value %h index %0d sat %0b last %0b",
                                 term.term_value, term.term_index, term.saturated,
                                 term.run_last);
                end
                else
                begin
                    want = expected_terms.pop_front();
                    if (term.term_value !== want.value || term.term_index !== want.index ||
                        term.saturated !== want.saturated || term.run_last !== want.run_last)
                    begin
                        mismatches++;
                        if (mismatches <= REPORT_MAX)
                            $display("term mismatch: exp %h/%0d/%0b/%0b got %h/%0d/%0b/%0b",
                                     want.value, want.index, want.saturated, want.run_last,
                                     term.term_value, term.term_index, term.saturated,
                                     term.run_last);
                    end
                end
            end
            if (coord.valid && coord.ready)
                extend_series(coord.coord_value, coord.last_coord);
            if (psel && penable && pwrite && pready)
            begin
                if (paddr[2] == REG_SERIES_LENGTH)
                    length_cfg = pwdata[LEN_W-1:0];
                else
                    degree_cfg = pwdata[DEG_W-1:0];
            end
            outstanding = expected_terms.size();
        end
    end

endmodule

// File: tb/sv/tb_tensor_polynomial_feature_series.sv
// ----------------------------------------------------------------------------
// tb_tensor_polynomial_feature_series
// Drives coordinate vectors and register writes into the feature series block,
// with random gaps on both channels, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module tb_tensor_polynomial_feature_series;
    import tpfs_pkg::*;

    localparam int QUIET_LIMIT  = 5000;
    localparam int HOLD_OFF     = 100;
    localparam int RANDOM_ITEMS = 150;
    localparam int IDLE_PCT     = 36;

    logic                  clk   = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  calm;
    int                    mismatches;
    int                    outstanding;
    int                    quiet_cycles;

    tpfs_coord_if coord_ch ();
    tpfs_term_if  term_ch ();

    tensor_polynomial_feature_series i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .coord   (coord_ch),
        .term    (term_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    tpfs_series_checker i_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .coord       (coord_ch),
        .term        (term_ch),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .pready      (pready),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    always #2 clk = ~clk;

    always @(negedge clk)
        term_ch.ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);

    // Nothing accepted on any channel for too long means the block hung.
    always @(posedge clk)
    begin
        if ((coord_ch.valid && coord_ch.ready) || (term_ch.valid && term_ch.ready) ||
            (psel && penable))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    function automatic logic [COORD_W-1:0] pick_coord();
        int                 r;
        logic [COORD_W-1:0] v;
        r = $urandom_range(0, 99);
        if (r < 40)
            v = $urandom_range(0, 32'h0006_0000) - 32'h0003_0000;
        else if (r < 60)
        begin
            v = $urandom_range(0, 32'h0000_FFFF);
            if ($urandom_range(0, 1))
                v = -v;
        end
        else if (r < 85)
            v = $urandom;
        else
        begin
            case ($urandom_range(0, 6))
                0:       v = 32'h0000_0000;
                1:       v = 32'h0001_0000;
                2:       v = 32'hFFFF_0000;
                3:       v = 32'h7FFF_FFFF;
                4:       v = 32'h8000_0000;
                5:       v = 32'hFFFF_FFFF;
                default: v = 32'h0000_0001;
            endcase
        end
        return v;
    endfunction

    function automatic logic [LEN_W-1:0] pick_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 5)
            return '0;
        if (r < 12)
            return LEN_W'($urandom_range(65, 127));
        if (r < 20)
            return 7'd64;
        return LEN_W'($urandom_range(1, 64));
    endfunction

    function automatic logic [DEG_W-1:0] pick_degree();
        int r;
        r = $urandom_range(0, 99);
        if (r < 6)
            return '0;
        if (r < 70)
            return DEG_W'($urandom_range(1, 4));
        return DEG_W'($urandom_range(5, 63));
    endfunction

    task automatic send_coord(input logic [COORD_W-1:0] x, input logic last);
        while (!calm && $urandom_range(0, 99) < IDLE_PCT)
        begin
            coord_ch.valid <= 1'b0;
            @(negedge clk);
        end
        coord_ch.valid       <= 1'b1;
        coord_ch.coord_value <= x;
        coord_ch.last_coord  <= last;
        do
            @(posedge clk);
        while (!coord_ch.ready);
        @(negedge clk);
    endtask

    task automatic apb_write(input logic reg_idx, input logic [APB_DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_idx, 2'b00};
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge clk);
    endtask

    // Lets every expected term drain, then gives the sequencer time to settle
    // after a coordinate that emitted nothing.
    task automatic wait_quiet();
        coord_ch.valid <= 1'b0;
        @(negedge clk);
        while (outstanding != 0)
            @(negedge clk);
        repeat (HOLD_OFF) @(negedge clk);
    endtask

    task automatic set_config(input logic [LEN_W-1:0] len, input logic [DEG_W-1:0] deg);
        logic [APB_DATA_W-1:0] data;
        wait_quiet();
        data            = $urandom;
        data[LEN_W-1:0] = len;
        apb_write(REG_SERIES_LENGTH, data);
        data            = $urandom;
        data[DEG_W-1:0] = deg;
        apb_write(REG_MAX_DEGREE, data);
    endtask

    initial
    begin
        int   sent;
        int   dim;
        int   i;
        logic broken;
        logic last;
        coord_ch.valid       = 1'b0;
        coord_ch.coord_value = '0;
        coord_ch.last_coord  = 1'b0;
        term_ch.ready        = 1'b0;
        psel                 = 1'b0;
        penable              = 1'b0;
        pwrite               = 1'b0;
        paddr                = '0;
        pwdata               = '0;
        calm                 = 1'b0;
        quiet_cycles         = 0;
        repeat (7) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Register values after reset, with both extremes of the coordinate.
        send_coord(32'h7FFF_FFFF, 1'b0);
        send_coord(32'h8000_0000, 1'b1);
        // A zero length still gives the leading one.
        set_config('0, 6'd5);
        send_coord(32'h0001_8000, 1'b1);
        // Zero degree with a length above the store size.
        set_config(7'd127, '0);
        send_coord(32'h0001_0000, 1'b0);
        send_coord(32'h0002_0000, 1'b1);
        // Powers of two run past the range and stay clamped.
        set_config(7'd64, 6'd63);
        send_coord(32'h0002_0000, 1'b1);
        // Fills the series, then coordinates that add nothing until the end.
        set_config(7'd64, 6'd2);
        send_coord(32'hFFFF_0000, 1'b0);
        send_coord(32'h0000_8000, 1'b0);
        send_coord(32'hFFFF_FFFF, 1'b0);
        send_coord(32'h0000_0000, 1'b0);
        send_coord(32'h1234_5678, 1'b0);
        send_coord(32'hFFFE_8000, 1'b1);
        // Length lowered below what the vector already holds.
        send_coord(32'h0001_0000, 1'b0);
        set_config(7'd2, 6'd2);
        send_coord(32'h0002_0000, 1'b1);
        set_config(7'd1, 6'd63);
        send_coord(32'h0003_0000, 1'b1);

        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            set_config(pick_length(), pick_degree());
            repeat ($urandom_range(1, 4))
            begin
                dim    = $urandom_range(1, 6);
                broken = ($urandom_range(0, 99) < 15);
                for (i = 0; i < dim; i++)
                begin
                    calm <= (sent >= 70 && sent < 110);
                    last = broken ? 1'($urandom_range(0, 1)) : (i == dim - 1);
                    send_coord(pick_coord(), last);
                    sent++;
                    if (!last && $urandom_range(0, 99) < 8)
                        set_config(pick_length(), pick_degree());
                end
            end
        end

        wait_quiet();
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
